FILE: sv/b64se_pkg.sv
// Shared types, register codes and the sextet-to-character map for the Base64 stream encoder.
// No dependencies.
package b64se_pkg;

	localparam int MAX_BREAK_CHARS = 2;
	// Break length cap: the configured limit, never more than the two break characters.
	localparam int BREAK_CAP = (MAX_BREAK_CHARS < 2) ? MAX_BREAK_CHARS : 2;
	localparam int RES_MAX = 4;      // characters one item can cause
	localparam int PADDR_W = 5;

	typedef logic [7:0] char_t;

	typedef enum logic [2:0] {
		REG_URL_SAFE    = 3'd0,
		REG_LINE_LIMIT  = 3'd1,
		REG_BREAK_LEN   = 3'd2,
		REG_BREAK_FIRST = 3'd3,
		REG_BREAK_SECOND = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        url_safe;
		logic [15:0] line_limit;
		logic [1:0]  break_len;
		char_t       break_first;
		char_t       break_second;
	} cfg_t;

	// Characters caused by one item, slot 0 sent first, plus their count (1..4).
	typedef struct packed {
		char_t [RES_MAX-1:0] chars;
		logic [2:0]          count;
	} enc_res_t;

	localparam char_t CHAR_PAD = 8'h3d;   // '='

	function automatic char_t sextet_char(input logic [5:0] v, input logic url);
		char_t c;
		if (v < 6'd26) begin
			c = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'd71 + {2'b00, v};          // 'a' + (v - 26)
		end else if (v < 6'd62) begin
			c = {2'b00, v} - 8'd4;           // '0' + (v - 52)
		end else if (v == 6'd62) begin
			c = url ? 8'h2d : 8'h2b;         // '-' or '+'
		end else begin
			c = url ? 8'h5f : 8'h2f;         // '_' or '/'
		end
		return c;
	endfunction

endpackage

FILE: sv/b64se_cfg_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on b64se_pkg.
module b64se_cfg_regs
	import b64se_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.url_safe     <= 1'b0;
			cfg_q.line_limit   <= 16'd76;
			cfg_q.break_len    <= 2'd0;
			cfg_q.break_first  <= 8'd13;
			cfg_q.break_second <= 8'd10;
		end else if (wr_en) begin
			unique case (widx)
				REG_URL_SAFE:     cfg_q.url_safe     <= pwdata[0];
				REG_LINE_LIMIT:   cfg_q.line_limit   <= pwdata[15:0];
				REG_BREAK_LEN:    cfg_q.break_len    <= pwdata[1:0];
				REG_BREAK_FIRST:  cfg_q.break_first  <= pwdata[7:0];
				REG_BREAK_SECOND: cfg_q.break_second <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (widx)
			REG_URL_SAFE:     prdata = {31'd0, cfg_q.url_safe};
			REG_LINE_LIMIT:   prdata = {16'd0, cfg_q.line_limit};
			REG_BREAK_LEN:    prdata = {30'd0, cfg_q.break_len};
			REG_BREAK_FIRST:  prdata = {24'd0, cfg_q.break_first};
			REG_BREAK_SECOND: prdata = {24'd0, cfg_q.break_second};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

FILE: sv/b64se_group_enc.sv
// Group encoder: phase, carry and line-count state plus the per-byte character logic.
// Depends on b64se_pkg.
module b64se_group_enc
	import b64se_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     take,       // item accepted this cycle
	input  char_t    data_byte,
	input  logic     final_byte,
	output enc_res_t res
);

	logic [1:0]  group_phase_q, phase_d;
	logic [3:0]  carry_bits_q, carry_d;
	logic [13:0] groups_on_line_q, groups_d;

	logic [16:0] span;
	logic [16:0] limit;
	logic        wrap;
	logic [1:0]  blen;

	always_comb begin
		span  = ({3'd0, groups_on_line_q} + 17'd2) << 2;
		limit = (cfg.line_limit < 16'd4) ? 17'd4 : {1'b0, cfg.line_limit};
		wrap  = span >= limit;
		blen  = (cfg.break_len > 2'(BREAK_CAP)) ? 2'(BREAK_CAP) : cfg.break_len;
	end

	always_comb begin
		res.chars = '0;
		res.count = 3'd1;
		phase_d   = group_phase_q;
		carry_d   = carry_bits_q;
		groups_d  = groups_on_line_q;
		case (group_phase_q)
			2'd1: begin
				res.chars[0] = sextet_char({carry_bits_q[1:0], data_byte[7:4]}, cfg.url_safe);
				if (final_byte) begin
					res.chars[1] = sextet_char({data_byte[3:0], 2'b00}, cfg.url_safe);
					res.chars[2] = CHAR_PAD;
					res.count    = 3'd3;
				end else begin
					carry_d = data_byte[3:0];
					phase_d = 2'd2;
				end
			end
			2'd2: begin
				res.chars[0] = sextet_char({carry_bits_q, data_byte[7:6]}, cfg.url_safe);
				res.chars[1] = sextet_char(data_byte[5:0], cfg.url_safe);
				res.count    = 3'd2;
				if (!final_byte) begin
					if (wrap) begin
						res.chars[2] = cfg.break_first;
						res.chars[3] = cfg.break_second;
						res.count    = 3'd2 + {1'b0, blen};
						groups_d     = '0;
					end else begin
						groups_d = groups_on_line_q + 14'd1;
					end
					carry_d = '0;
					phase_d = 2'd0;
				end
			end
			default: begin
				// phase 0; the unused code behaves the same
				res.chars[0] = sextet_char(data_byte[7:2], cfg.url_safe);
				if (final_byte) begin
					res.chars[1] = sextet_char({data_byte[1:0], 4'b0000}, cfg.url_safe);
					res.chars[2] = CHAR_PAD;
					res.chars[3] = CHAR_PAD;
					res.count    = 3'd4;
				end else begin
					carry_d = {2'b00, data_byte[1:0]};
					phase_d = 2'd1;
				end
			end
		endcase
		if (final_byte) begin
			phase_d  = '0;
			carry_d  = '0;
			groups_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_phase_q    <= '0;
			carry_bits_q     <= '0;
			groups_on_line_q <= '0;
		end else if (take) begin
			group_phase_q    <= phase_d;
			carry_bits_q     <= carry_d;
			groups_on_line_q <= groups_d;
		end
	end

endmodule

FILE: sv/b64se_char_buf.sv
// Result register: holds the characters of one item and sends them one per cycle while out_ready is high.
// Depends on b64se_pkg.
module b64se_char_buf
	import b64se_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  enc_res_t res,
	output logic     room,       // may load this cycle
	output logic     out_valid,
	input  logic     out_ready,
	output char_t    out_char,
	output logic     out_last
);

	char_t [RES_MAX-1:0] chars_q;
	logic [2:0]          cnt_q;      // characters still to send
	logic [1:0]          idx_q;      // next slot to send
	logic                send;

	assign out_valid = cnt_q != 3'd0;
	assign out_last  = cnt_q == 3'd1;
	assign out_char  = chars_q[idx_q];
	assign send      = out_valid & out_ready;
	assign room      = (cnt_q == 3'd0) | (out_last & out_ready);

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= res.chars;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
			idx_q <= '0;
		end else if (send) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(RES_MAX))
		else $error("char buffer count out of range");

	a_slots_fit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, idx_q} + cnt_q) <= 3'(RES_MAX))
		else $error("char buffer reads past its slots");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid && idx_q == 2'd0)
		else $error("loaded item not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && out_ready)))
		else $error("load over characters not yet sent");

endmodule

FILE: sv/base64_stream_encoder_unit.sv
// Top level of the Base64 stream encoder: config registers, group encoder, char buffer.
// Depends on b64se_pkg, b64se_cfg_regs, b64se_group_enc, b64se_char_buf.
//
// Usage:
//   s_axis carries one input byte per item (tdata[7:0]); tlast marks the final
//   byte of a message, which closes the group with '=' padding and clears state.
//   m_axis carries one output character per item (tdata[7:0]); tlast is set on
//   the last character caused by an input byte (1 to 4 characters per byte).
//   After each full group that is not final, a break of up to two characters
//   is appended once the line would reach line_limit (values below 4 act as 4).
//   The APB port writes/reads the five registers at byte addresses 0,4,...,16.
// Timing:
//   An accepted byte is encoded in the same cycle into the character buffer;
//   its first character is offered on the next cycle. Characters leave one per
//   cycle while m_axis_tready is high; a byte makes 1 to 4 characters (about 4/3
//   on average with no breaks), and the next byte is taken in the cycle its
//   predecessor's last character is taken.
//   The one-character output channel sets the rate.
// Reset: arst_n clears phase, carry, line count and buffer; registers go to
//   0, 76, 0, 13, 10. A stalled receiver holds the current character and
//   s_axis_tready stays low until the last buffered character is taken.
module base64_stream_encoder_unit
	import b64se_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input bytes
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  logic               s_axis_tlast,   // final_byte
	// output characters
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,   // [7:0] out_char
	output logic               m_axis_tlast,   // out_last
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t     cfg;
	enc_res_t res;
	logic     room;
	logic     take;

	// byte taken whenever the buffer is empty or frees up this cycle
	assign s_axis_tready = room;
	assign take          = s_axis_tvalid & room;

	b64se_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	b64se_group_enc u_enc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.take       (take),
		.data_byte  (s_axis_tdata),
		.final_byte (s_axis_tlast),
		.res        (res)
	);

	b64se_char_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res       (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
